// ===== rtl/core/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// shared types, widths and codes for the bounded stack with search and remove
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  localparam int DEPTH    = 8;
  localparam int KEY_BITS = 64;

  localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int KEY_W    = 64;
  localparam int OCC_W    = 4;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [KEY_W-1:0]    field_key_t;
  typedef logic [OCC_W-1:0]    occ_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] popped_key;
    logic             found;
    logic [KEY_W-1:0] top_key;
    logic [OCC_W-1:0] occupancy;
    logic             is_full;
    logic             is_empty;
  } out_word_t;

  typedef struct packed {
    logic rd_en;
    ptr_t rd_addr;
    logic wr_en;
    ptr_t wr_addr;
    key_t wr_data;
  } mem_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_TOP_RD,
    S_TOP_WAIT,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bounded_stack_search_remove.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_search_remove
// lifo key stack with push, pop, search and order-keeping remove, run by a
// small sequencer over one storage read port and one key comparator
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  cmd, key
//   out_     output     out_valid / out_stall status, popped_key, found,
//                                            top_key, occupancy, flags
//
// one command at a time; a push writes then reads the new top key, a pop reads
// the popped entry, then the new top; search compares entries from the top down
// remove then moves each entry above the match down through the read port
// any command that leaves the stack empty skips the top-key read
// in_stall is high from accept until the result word is taken
// synchronous active-low reset empties the stack; stored keys are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_search_remove (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire bss_pkg::in_word_t   in_word,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      bss_pkg::out_word_t  out_word
);

  bss_pkg::state_t state_r, state_nxt;
  bss_pkg::cnt_t   cnt_r, cnt_nxt;
  bss_pkg::ptr_t   idx_r, idx_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  bss_pkg::key_t   key_r, key_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            found_r, found_nxt;
  bss_pkg::key_t   popped_r, popped_nxt;
  bss_pkg::key_t   top_r, top_nxt;

  bss_pkg::mem_ctl_t ctl;
  bss_pkg::key_t     rd_data;
  logic              hit;

  logic          accept;
  bss_pkg::cnt_t cnt_m1;
  bss_pkg::cnt_t idx_p1;
  logic          is_full_c;
  logic          is_empty_c;

  assign accept     = in_valid && !in_stall;
  assign cnt_m1     = cnt_r - bss_pkg::CNT_W'(1);
  assign idx_p1     = bss_pkg::CNT_W'(idx_r) + bss_pkg::CNT_W'(1);
  assign is_full_c  = (cnt_r == bss_pkg::CNT_W'(bss_pkg::DEPTH));
  assign is_empty_c = (cnt_r == '0);

  bss_store u_store (
    .clk     (clk),
    .ctl     (ctl),
    .cmp_key (key_r),
    .rd_data (rd_data),
    .hit     (hit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bss_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = bss_pkg::S_EXEC;
        end
      end
      bss_pkg::S_EXEC: begin
        if (cmd_r == bss_pkg::CMD_PUSH) begin
          state_nxt = bss_pkg::S_TOP_RD;
        end else if (is_empty_c) begin
          state_nxt = bss_pkg::S_TOP_RD;
        end else if (cmd_r == bss_pkg::CMD_POP) begin
          state_nxt = bss_pkg::S_POP_WAIT;
        end else begin
          state_nxt = bss_pkg::S_SCAN_RD;
        end
      end
      bss_pkg::S_POP_WAIT: state_nxt = bss_pkg::S_TOP_RD;
      bss_pkg::S_SCAN_RD:  state_nxt = bss_pkg::S_SCAN_CMP;
      bss_pkg::S_SCAN_CMP: begin
        if (hit) begin
          state_nxt = (cmd_r == bss_pkg::CMD_REMOVE) ? bss_pkg::S_SHIFT_RD
                                                     : bss_pkg::S_TOP_RD;
        end else if (idx_r == '0) begin
          state_nxt = bss_pkg::S_TOP_RD;
        end else begin
          state_nxt = bss_pkg::S_SCAN_RD;
        end
      end
      bss_pkg::S_SHIFT_RD: begin
        state_nxt = (idx_p1 < cnt_r) ? bss_pkg::S_SHIFT_WR : bss_pkg::S_TOP_RD;
      end
      bss_pkg::S_SHIFT_WR: state_nxt = bss_pkg::S_SHIFT_RD;
      bss_pkg::S_TOP_RD: begin
        state_nxt = is_empty_c ? bss_pkg::S_OUT : bss_pkg::S_TOP_WAIT;
      end
      bss_pkg::S_TOP_WAIT: state_nxt = bss_pkg::S_OUT;
      bss_pkg::S_OUT: begin
        if (!out_stall) begin
          state_nxt = bss_pkg::S_IDLE;
        end
      end
      default: state_nxt = bss_pkg::S_IDLE;
    endcase
  end

  // storage control and datapath
  always_comb begin
    ctl        = '0;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    popped_nxt = popped_r;
    top_nxt    = top_r;
    case (state_r)
      bss_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_word.cmd;
          key_nxt    = in_word.key[bss_pkg::KEY_BITS-1:0];
          status_nxt = bss_pkg::ST_OK;
          found_nxt  = 1'b0;
          popped_nxt = '0;
        end
      end
      bss_pkg::S_EXEC: begin
        if (cmd_r == bss_pkg::CMD_PUSH) begin
          if (is_full_c) begin
            status_nxt = bss_pkg::ST_FULL;
          end else begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = cnt_r[bss_pkg::PTR_W-1:0];
            ctl.wr_data = key_r;
            cnt_nxt     = cnt_r + bss_pkg::CNT_W'(1);
          end
        end else if (is_empty_c) begin
          status_nxt = bss_pkg::ST_EMPTY;
        end else if (cmd_r == bss_pkg::CMD_POP) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = cnt_m1[bss_pkg::PTR_W-1:0];
          cnt_nxt     = cnt_m1;
        end else begin
          idx_nxt = cnt_m1[bss_pkg::PTR_W-1:0];
        end
      end
      bss_pkg::S_POP_WAIT: begin
        popped_nxt = rd_data;
      end
      bss_pkg::S_SCAN_RD: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = idx_r;
      end
      bss_pkg::S_SCAN_CMP: begin
        if (hit) begin
          found_nxt = 1'b1;
        end else if (idx_r == '0) begin
          status_nxt = bss_pkg::ST_NOTFOUND;
        end else begin
          idx_nxt = idx_r - bss_pkg::PTR_W'(1);
        end
      end
      bss_pkg::S_SHIFT_RD: begin
        if (idx_p1 < cnt_r) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = idx_p1[bss_pkg::PTR_W-1:0];
        end else begin
          cnt_nxt = cnt_m1;
        end
      end
      bss_pkg::S_SHIFT_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = idx_r;
        ctl.wr_data = rd_data;
        idx_nxt     = idx_p1[bss_pkg::PTR_W-1:0];
      end
      bss_pkg::S_TOP_RD: begin
        if (is_empty_c) begin
          top_nxt = '0;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = cnt_m1[bss_pkg::PTR_W-1:0];
        end
      end
      bss_pkg::S_TOP_WAIT: begin
        top_nxt = rd_data;
      end
      bss_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bss_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    popped_r <= popped_nxt;
    top_r    <= top_nxt;
  end

  assign in_stall  = (state_r != bss_pkg::S_IDLE);
  assign out_valid = (state_r == bss_pkg::S_OUT);

  always_comb begin
    out_word.status     = status_r;
    out_word.popped_key = bss_pkg::field_key_t'(popped_r);
    out_word.found      = found_r;
    out_word.top_key    = bss_pkg::field_key_t'(top_r);
    out_word.occupancy  = bss_pkg::occ_t'(cnt_r);
    out_word.is_full    = is_full_c;
    out_word.is_empty   = is_empty_c;
  end

endmodule

`default_nettype wire

// ===== rtl/core/bss_store.sv =====
// ----------------------------------------------------------------------------
// bss_store
// key storage with one write port, one registered read port and the shared
// key comparator
// ----------------------------------------------------------------------------
`default_nettype none

module bss_store (
  input  wire logic              clk,
  input  wire bss_pkg::mem_ctl_t ctl,
  input  wire bss_pkg::key_t     cmp_key,
  output      bss_pkg::key_t     rd_data,
  output      logic              hit
);

  bss_pkg::key_t mem [bss_pkg::DEPTH];
  bss_pkg::key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign hit     = (rd_data_r == cmp_key);

endmodule

`default_nettype wire

// ===== sim/tb_bounded_stack_search_remove.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_stack_search_remove
// self-checking bench for the key stack: a directed table covering empty and
// full corners, duplicates and order-keeping remove, then random command mixes
// that drift between growing and shrinking the stack, under several sender
// idle and receiver stall profiles; every result word is checked field by
// field against its table word or against a behavioral copy of the stack
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounded_stack_search_remove;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam bss_pkg::field_key_t KEY_ONES = '1;
  localparam bss_pkg::field_key_t KEY_ALT_A = 64'h5555_5555_5555_5555;
  localparam bss_pkg::field_key_t KEY_ALT_B = 64'haaaa_aaaa_aaaa_aaaa;
  localparam bss_pkg::field_key_t KEY_MSB = 64'h8000_0000_0000_0000;
  localparam bss_pkg::field_key_t KEY_TOP = 64'h0000_0000_0000_1234;
  localparam bss_pkg::field_key_t KEY_MISS = 64'h7777_7777_7777_7777;

  typedef struct {
    logic [1:0]          cmd;
    bss_pkg::field_key_t key;
    bit                  typed;
    bss_pkg::out_word_t  result;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bss_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bss_pkg::out_word_t out_word;

  bss_pkg::key_t       stack_keys [bss_pkg::DEPTH];
  int                  stack_fill = 0;
  bss_pkg::out_word_t  pending_results [$];
  bss_pkg::out_word_t  head_result;
  stim_row_t           stim_rows [$];
  bss_pkg::field_key_t key_pool [8];
  bit                  grow_mode = 1'b1;
  int                  idle_pct = 0;
  int                  stall_pct = 0;
  int                  hold_req_count = 0;
  int                  hold_served = 0;
  int                  hold_left = 0;
  int                  mismatches = 0;
  int                  cycle_count = 0;

  bounded_stack_search_remove i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic bss_pkg::out_word_t flag_word(logic [1:0] status,
                                                   bss_pkg::field_key_t top, int occ);
    bss_pkg::out_word_t r;
    r = '0;
    r.status = status;
    r.top_key = top;
    r.occupancy = bss_pkg::occ_t'(occ);
    r.is_full = (occ == bss_pkg::DEPTH);
    r.is_empty = (occ == 0);
    return r;
  endfunction

  function automatic bss_pkg::out_word_t stack_apply(bss_pkg::in_word_t w);
    bss_pkg::out_word_t r;
    bss_pkg::key_t k;
    int n;
    int hit;
    k = bss_pkg::key_t'(w.key);
    n = stack_fill;
    r = '0;
    r.status = bss_pkg::ST_OK;
    case (w.cmd)
      bss_pkg::CMD_PUSH: begin
        if (n >= bss_pkg::DEPTH) begin
          r.status = bss_pkg::ST_FULL;
        end else begin
          stack_keys[n] = k;
          n++;
        end
      end
      bss_pkg::CMD_POP: begin
        if (n == 0) begin
          r.status = bss_pkg::ST_EMPTY;
        end else begin
          n--;
          r.popped_key = bss_pkg::field_key_t'(stack_keys[n]);
        end
      end
      default: begin
        if (n == 0) begin
          r.status = bss_pkg::ST_EMPTY;
        end else begin
          hit = -1;
          for (int i = n - 1; i >= 0 && hit < 0; i--) begin
            if (stack_keys[i] == k) hit = i;
          end
          if (hit < 0) begin
            r.status = bss_pkg::ST_NOTFOUND;
          end else begin
            r.found = 1'b1;
            if (w.cmd == bss_pkg::CMD_REMOVE) begin
              for (int i = hit; i < n - 1; i++) stack_keys[i] = stack_keys[i + 1];
              n--;
            end
          end
        end
      end
    endcase
    stack_fill = n;
    if (n > 0) r.top_key = bss_pkg::field_key_t'(stack_keys[n - 1]);
    r.occupancy = bss_pkg::occ_t'(n);
    r.is_full = (n == bss_pkg::DEPTH);
    r.is_empty = (n == 0);
    return r;
  endfunction

  function automatic bss_pkg::in_word_t next_random_word();
    bss_pkg::in_word_t w;
    int roll;
    if ($urandom_range(39) == 0) grow_mode = !grow_mode;
    roll = $urandom_range(99);
    if (grow_mode) begin
      w.cmd = (roll < 50) ? bss_pkg::CMD_PUSH : (roll < 65) ? bss_pkg::CMD_POP :
              (roll < 85) ? bss_pkg::CMD_SEARCH : bss_pkg::CMD_REMOVE;
    end else begin
      w.cmd = (roll < 15) ? bss_pkg::CMD_PUSH : (roll < 55) ? bss_pkg::CMD_POP :
              (roll < 75) ? bss_pkg::CMD_SEARCH : bss_pkg::CMD_REMOVE;
    end
    roll = $urandom_range(99);
    if (w.cmd != bss_pkg::CMD_PUSH && stack_fill > 0 && roll < 60) begin
      w.key = bss_pkg::field_key_t'(stack_keys[$urandom_range(stack_fill - 1)]);
    end else begin
      roll = $urandom_range(9);
      if (roll < 3) w.key = {$urandom, $urandom};
      else if (roll == 3) w.key = $urandom_range(1) ? KEY_ONES : '0;
      else w.key = key_pool[$urandom_range(7)];
    end
    return w;
  endfunction

  function automatic void cmp_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word);
      end else begin
        head_result = pending_results.pop_front();
        cmp_field("status", 64'(out_word.status), 64'(head_result.status));
        cmp_field("popped_key", out_word.popped_key, head_result.popped_key);
        cmp_field("found", 64'(out_word.found), 64'(head_result.found));
        cmp_field("top_key", out_word.top_key, head_result.top_key);
        cmp_field("occupancy", 64'(out_word.occupancy), 64'(head_result.occupancy));
        cmp_field("is_full", 64'(out_word.is_full), 64'(head_result.is_full));
        cmp_field("is_empty", 64'(out_word.is_empty), 64'(head_result.is_empty));
      end
    end
  end

  // receiver stall, with long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req_count != hold_served) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_served <= hold_req_count;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(bss_pkg::in_word_t w, bit typed,
                           bss_pkg::out_word_t typed_result);
    bss_pkg::out_word_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = stack_apply(w);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle, int stall, int count);
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    idle_pct = idle;
    stall_pct <= stall;
    repeat (count) send_word(next_random_word(), 1'b0, '0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    stim_rows.push_back('{bss_pkg::CMD_POP, KEY_ONES, 1'b1,
                          flag_word(bss_pkg::ST_EMPTY, '0, 0)});
    stim_rows.push_back('{bss_pkg::CMD_SEARCH, '0, 1'b1,
                          flag_word(bss_pkg::ST_EMPTY, '0, 0)});
    stim_rows.push_back('{bss_pkg::CMD_REMOVE, KEY_ONES, 1'b1,
                          flag_word(bss_pkg::ST_EMPTY, '0, 0)});
    stim_rows.push_back('{bss_pkg::CMD_PUSH, '0, 1'b1, flag_word(bss_pkg::ST_OK, '0, 1)});
    stim_rows.push_back('{bss_pkg::CMD_PUSH, KEY_ONES, 1'b1,
                          flag_word(bss_pkg::ST_OK, KEY_ONES, 2)});
    stim_rows.push_back('{bss_pkg::CMD_PUSH, KEY_ALT_A, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_PUSH, KEY_ALT_B, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_PUSH, KEY_ALT_A, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_PUSH, 64'h1, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_PUSH, KEY_MSB, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_PUSH, KEY_TOP, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_PUSH, KEY_MISS, 1'b1,
                          flag_word(bss_pkg::ST_FULL, KEY_TOP, bss_pkg::DEPTH)});
    stim_rows.push_back('{bss_pkg::CMD_SEARCH, KEY_ALT_A, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_SEARCH, KEY_MISS, 1'b1,
                          flag_word(bss_pkg::ST_NOTFOUND, KEY_TOP, bss_pkg::DEPTH)});
    stim_rows.push_back('{bss_pkg::CMD_REMOVE, KEY_MISS, 1'b1,
                          flag_word(bss_pkg::ST_NOTFOUND, KEY_TOP, bss_pkg::DEPTH)});
    // duplicate key: only the upper copy goes
    stim_rows.push_back('{bss_pkg::CMD_REMOVE, KEY_ALT_A, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_SEARCH, KEY_ALT_A, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_REMOVE, KEY_TOP, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_REMOVE, '0, 1'b0, '0});
    repeat (5) stim_rows.push_back('{bss_pkg::CMD_POP, KEY_ALT_B, 1'b0, '0});
    stim_rows.push_back('{bss_pkg::CMD_POP, '0, 1'b1, flag_word(bss_pkg::ST_EMPTY, '0, 0)});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      send_word('{cmd: stim_rows[i].cmd, key: stim_rows[i].key}, stim_rows[i].typed,
                stim_rows[i].result);
    end
    in_valid <= 1'b0;
    wait_drained();

    run_phase(0, 0, 300);
    run_phase(80, 0, 300);
    run_phase(0, 80, 300);
    run_phase(37, 37, 300);

    // long receiver hold-off while words keep coming
    hold_req_count <= hold_req_count + 1;
    run_phase(0, 0, 30);

    run_phase(0, 0, 270);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
